// ----- rtl/ost_pkg.sv -----
// ----------------------------------------------------------------------------
// ost_pkg: shared types and constants of the occupancy slot table
// Slot geometry, field widths, command and status codes, and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ost_pkg;

  // Slot geometry and field widths.
  localparam int SlotNum  = 256;
  localparam int SlotAw   = 8;
  localparam int CntW     = 9;
  localparam int ValW     = 32;
  localparam int CmdW     = 3;
  localparam int StW      = 2;
  localparam int InitCap  = 16;

  // Packed stream widths, rounded up to whole bytes.
  localparam int InFieldW  = CmdW + CntW + ValW;
  localparam int InW       = ((InFieldW + 7) / 8) * 8;
  localparam int OutFieldW = ValW + SlotAw + 1 + StW + CntW + CntW;
  localparam int OutW      = ((OutFieldW + 7) / 8) * 8;

  // Reset values of the capacity and the chunk register.
  localparam logic [CntW-1:0] CapRst   = CntW'((InitCap > SlotNum) ? SlotNum : InitCap);
  localparam logic [CntW-1:0] ChunkRst = CntW'(16);

  // Command codes; code 7 is a no-operation.
  typedef enum logic [CmdW-1:0] {
    CMD_GET    = 3'd0,
    CMD_SET    = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_PUSH   = 3'd3,
    CMD_POP    = 3'd4,
    CMD_NEXT   = 3'd5,
    CMD_PREV   = 3'd6
  } cmd_e;

  // Result status codes.
  typedef enum logic [StW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } st_e;

  // Strobes from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the input transaction
    logic look;    // search valid bits, issue the slot read
    logic exec;    // apply the command, write back
    logic shrink;  // check the top chunk and contract
    logic emit;    // load the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic shrink_chk;  // the command just executed may contract capacity
    logic out_free;    // output register can take a result
  } dp_sts_t;

endpackage

// ----- rtl/ost_find.sv -----
// ----------------------------------------------------------------------------
// ost_find: priority search over the slot valid bits
// Finds the highest set bit of one vector and the lowest set bit of another
// through a binary tree of compare-select nodes.
// ----------------------------------------------------------------------------
module ost_find (
  input  logic [ost_pkg::SlotNum-1:0] hi_vec_i,
  input  logic [ost_pkg::SlotNum-1:0] lo_vec_i,
  output logic                        hi_fnd_o,
  output logic [ost_pkg::SlotAw-1:0]  hi_pos_o,
  output logic                        lo_fnd_o,
  output logic [ost_pkg::SlotAw-1:0]  lo_pos_o
);
  import ost_pkg::*;

  logic [SlotNum-1:0] hany [0:SlotAw];
  logic [SlotNum-1:0] lany [0:SlotAw];
  logic [SlotAw-1:0]  hpos [0:SlotAw][0:SlotNum-1];
  logic [SlotAw-1:0]  lpos [0:SlotAw][0:SlotNum-1];

  // Tree levels: each node keeps the higher (or lower) child that has a hit.
  always_comb begin
    for (int l = 0; l <= SlotAw; l++) begin
      hany[l] = '0;
      lany[l] = '0;
      for (int n = 0; n < SlotNum; n++) begin
        hpos[l][n] = '0;
        lpos[l][n] = '0;
      end
    end
    hany[0] = hi_vec_i;
    lany[0] = lo_vec_i;
    for (int n = 0; n < SlotNum; n++) begin
      hpos[0][n] = SlotAw'(n);
      lpos[0][n] = SlotAw'(n);
    end
    for (int l = 0; l < SlotAw; l++) begin
      for (int n = 0; n < SlotNum / 2; n++) begin
        if (n < (SlotNum >> (l + 1))) begin
          hany[l+1][n] = hany[l][2*n] | hany[l][2*n+1];
          hpos[l+1][n] = hany[l][2*n+1] ? hpos[l][2*n+1] : hpos[l][2*n];
          lany[l+1][n] = lany[l][2*n] | lany[l][2*n+1];
          lpos[l+1][n] = lany[l][2*n] ? lpos[l][2*n] : lpos[l][2*n+1];
        end
      end
    end
  end

  assign hi_fnd_o = hany[SlotAw][0];
  assign hi_pos_o = hpos[SlotAw][0];
  assign lo_fnd_o = lany[SlotAw][0];
  assign lo_pos_o = lpos[SlotAw][0];

endmodule

// ----- rtl/ost_datapath.sv -----
// ----------------------------------------------------------------------------
// ost_datapath: slot memory, valid bits, counters and result register
// Executes one command in steps strobed by the controller: search, read,
// write-back, optional contraction check, and output load.
// ----------------------------------------------------------------------------
module ost_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ost_pkg::dp_cmd_t          ctl_i,
  output ost_pkg::dp_sts_t          sts_o,
  input  logic [ost_pkg::InW-1:0]   in_data_i,
  input  logic                      cfg_we_i,
  input  logic [ost_pkg::CntW-1:0]  cfg_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ost_pkg::OutW-1:0]  out_data_o
);
  import ost_pkg::*;

  // Captured command.
  logic [CmdW-1:0] cmd_q;
  logic [CntW-1:0] idx_q;
  logic [ValW-1:0] val_q;

  // Table state.
  logic [ValW-1:0]    mem [0:SlotNum-1];
  logic [SlotNum-1:0] valid_q, valid_d;
  logic [CntW-1:0]    live_q, live_d;
  logic [CntW-1:0]    cap_q, cap_d;
  logic [CntW-1:0]    chunk_q;

  // Search and read stage.
  logic [ValW-1:0]    rdata_q;
  logic [CntW-1:0]    tgt_q, tgt_d;
  logic               rng_q;
  logic               srch_fnd_q, srch_fnd_d;
  logic [SlotAw-1:0]  srch_pos_q, srch_pos_d;

  // Result register and output register.
  logic [ValW-1:0]    res_rd_q, res_rd_d;
  logic [SlotAw-1:0]  res_fidx_q, res_fidx_d;
  logic               res_fnd_q, res_fnd_d;
  logic [StW-1:0]     res_st_q, res_st_d;
  logic               out_valid_q;
  logic [OutW-1:0]    out_data_q;

  logic               idx_neg1, in_range;
  logic [SlotNum-1:0] below, above, hi_vec, lo_vec;
  logic               hi_fnd, lo_fnd;
  logic [SlotAw-1:0]  hi_pos, lo_pos;
  logic               vld_t, grow_need, grow_bad, wr, take;
  logic [CntW:0]      grown;
  logic [CntW-1:0]    floor_cap;

  // Input capture.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= in_data_i[CmdW-1:0];
      idx_q <= in_data_i[CmdW +: CntW];
      val_q <= in_data_i[CmdW+CntW +: ValW];
    end
  end

  // Index range tests and search masks.
  assign idx_neg1 = (idx_q == {CntW{1'b1}});
  assign in_range = !idx_q[CntW-1] && (idx_q < cap_q);

  always_comb begin
    for (int i = 0; i < SlotNum; i++) begin
      below[i] = (CntW'(i) < idx_q);
      above[i] = idx_q[CntW-1] || (CntW'(i) > idx_q);
    end
  end

  // The high search finds the top valid slot unless a previous-valid step narrows it.
  assign hi_vec = valid_q & (((cmd_q == CMD_PREV) && !idx_neg1) ? below : '1);
  assign lo_vec = valid_q & above;

  ost_find u_find (
    .hi_vec_i (hi_vec),
    .lo_vec_i (lo_vec),
    .hi_fnd_o (hi_fnd),
    .hi_pos_o (hi_pos),
    .lo_fnd_o (lo_fnd),
    .lo_pos_o (lo_pos)
  );

  // Target slot of the command.
  always_comb begin
    case (cmd_q)
      CMD_PUSH: tgt_d = (live_q == '0) ? '0 : ({1'b0, hi_pos} + CntW'(1));
      CMD_POP:  tgt_d = {1'b0, hi_pos};
      default:  tgt_d = idx_q;
    endcase
    srch_fnd_d = (cmd_q == CMD_NEXT) ? lo_fnd : hi_fnd;
    srch_pos_d = (cmd_q == CMD_NEXT) ? lo_pos : hi_pos;
  end

  // Search stage registers and the registered slot read.
  always_ff @(posedge clk_i) begin
    if (ctl_i.look) begin
      tgt_q      <= tgt_d;
      rng_q      <= in_range;
      srch_fnd_q <= srch_fnd_d;
      srch_pos_q <= srch_pos_d;
      rdata_q    <= mem[tgt_d[SlotAw-1:0]];
    end
  end

  // Growth check for set and push.
  assign vld_t     = !tgt_q[CntW-1] && valid_q[tgt_q[SlotAw-1:0]];
  assign grown     = {1'b0, cap_q} + {1'b0, chunk_q};
  assign grow_need = (tgt_q >= cap_q);
  assign grow_bad  = ({1'b0, tgt_q} >= grown) || (grown > (CntW+1)'(SlotNum));
  assign floor_cap = cap_q - chunk_q;

  // Command decode for the execute step.
  always_comb begin
    res_rd_d   = '0;
    res_fidx_d = '0;
    res_fnd_d  = 1'b0;
    res_st_d   = ST_OK;
    wr         = 1'b0;
    take       = 1'b0;
    case (cmd_q)
      CMD_GET: begin
        if (!rng_q) begin
          res_st_d = ST_RANGE;
        end else begin
          res_rd_d   = vld_t ? rdata_q : '0;
          res_fnd_d  = vld_t;
          res_fidx_d = tgt_q[SlotAw-1:0];
        end
      end
      CMD_SET, CMD_PUSH: begin
        if ((cmd_q == CMD_SET) && idx_q[CntW-1]) begin
          res_st_d = ST_RANGE;
        end else if (grow_need && grow_bad) begin
          res_st_d = ST_FULL;
        end else begin
          wr         = 1'b1;
          res_fnd_d  = 1'b1;
          res_fidx_d = tgt_q[SlotAw-1:0];
        end
      end
      CMD_REMOVE: begin
        if (!rng_q) begin
          res_st_d = ST_RANGE;
        end else begin
          take = vld_t;
        end
      end
      CMD_POP: begin
        take = (live_q != '0);
      end
      CMD_NEXT, CMD_PREV: begin
        if (!idx_neg1 && !rng_q) begin
          res_st_d = ST_RANGE;
        end else if ((live_q != '0) && srch_fnd_q) begin
          res_fnd_d  = 1'b1;
          res_fidx_d = srch_pos_q;
        end
      end
      default: begin
      end
    endcase
    if (take) begin
      res_rd_d   = rdata_q;
      res_fnd_d  = 1'b1;
      res_fidx_d = tgt_q[SlotAw-1:0];
    end
  end

  // Next table state for the execute and contraction steps.
  always_comb begin
    valid_d = valid_q;
    live_d  = live_q;
    cap_d   = cap_q;
    if (ctl_i.exec) begin
      if (wr) begin
        valid_d[tgt_q[SlotAw-1:0]] = 1'b1;
        if (!vld_t) begin
          live_d = live_q + CntW'(1);
        end
        if (grow_need) begin
          cap_d = grown[CntW-1:0];
        end
      end
      if (take) begin
        valid_d[tgt_q[SlotAw-1:0]] = 1'b0;
        live_d = live_q - CntW'(1);
      end
    end
    // Top chunk is clean when the highest valid slot lies below it.
    if (ctl_i.shrink && ({1'b0, hi_pos} < floor_cap)) begin
      cap_d = floor_cap;
    end
  end

  assign sts_o.shrink_chk = take && (live_q != CntW'(1)) && (chunk_q != '0) &&
                            (cap_q > chunk_q);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // Control state: valid bits, counters, chunk register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      live_q  <= '0;
      cap_q   <= CapRst;
      chunk_q <= ChunkRst;
    end else begin
      valid_q <= valid_d;
      live_q  <= live_d;
      cap_q   <= cap_d;
      if (cfg_we_i) begin
        chunk_q <= cfg_data_i;
      end
    end
  end

  // Slot memory write-back.
  always_ff @(posedge clk_i) begin
    if (ctl_i.exec && wr) begin
      mem[tgt_q[SlotAw-1:0]] <= val_q;
    end
  end

  // Result fields of the executed command.
  always_ff @(posedge clk_i) begin
    if (ctl_i.exec) begin
      res_rd_q   <= res_rd_d;
      res_fidx_q <= res_fidx_d;
      res_fnd_q  <= res_fnd_d;
      res_st_q   <= res_st_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      out_data_q <= OutW'({cap_q, live_q, res_st_q, res_fnd_q, res_fidx_q, res_rd_q});
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // The live counter always matches the number of valid bits.
  a_live_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(live_q))
    else $error("live count differs from valid bits");

  // Valid slots never exceed the capacity.
  a_live_le_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= cap_q)
    else $error("more live slots than capacity");

  // Capacity stays within one and the slot count.
  a_cap_bounds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cap_q != '0) && (cap_q <= CntW'(SlotNum)))
    else $error("capacity out of bounds");
`endif

endmodule

// ----- rtl/ost_ctrl.sv -----
// ----------------------------------------------------------------------------
// ost_ctrl: command sequencer of the occupancy slot table
// Steps one transaction through search, execute, optional contraction check
// and output load.
// ----------------------------------------------------------------------------
module ost_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output ost_pkg::dp_cmd_t  ctl_o,
  input  ost_pkg::dp_sts_t  sts_i
);
  import ost_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOOK   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_SHRINK = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state_q, state_d;

  // Next state and datapath strobes.
  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        ctl_o.load = in_valid_i;
        if (in_valid_i) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        ctl_o.look = 1'b1;
        state_d    = S_EXEC;
      end
      S_EXEC: begin
        ctl_o.exec = 1'b1;
        state_d    = sts_i.shrink_chk ? S_SHRINK : S_DONE;
      end
      S_SHRINK: begin
        ctl_o.shrink = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        ctl_o.emit = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  // An accepted transaction goes straight to the search step.
  a_accept_look : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_LOOK))
    else $error("accepted transaction did not start the search");

  // At most one datapath step per cycle.
  a_one_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl_o.load, ctl_o.look, ctl_o.exec, ctl_o.shrink, ctl_o.emit}))
    else $error("several datapath steps at once");

  // A result is only loaded when the output register can take it.
  a_emit_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.emit |-> sts_i.out_free)
    else $error("result loaded over a pending one");
`endif

endmodule

// ----- rtl/occupancy_slot_table.sv -----
// ----------------------------------------------------------------------------
// occupancy_slot_table: slot table with valid bits and chunked capacity
// Get, set, remove, push, pop, next-valid and previous-valid on 256 slots.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  s_axis    in         command, slot_index, element_value
//  m_axis    out        read_value, found_index, found, status, live_count,
//                       capacity_now
//  cfg       in         chunk_size
//
//  m_axis_tvalid rises once an accepted transaction has passed the search,
//  execute and output-load steps, and also the contraction check for a remove
//  or pop that must check whether the top chunk can be released.
//  The sequencer handles one transaction at a time: search of the valid bits,
//  a registered slot read, write-back, then the output load.
//  The input is ready again from the edge that loads the result, while that
//  result may still wait on m_axis_tready; a stalled output holds the
//  sequencer before its output load. Reset clears all valid bits at once.
//
module occupancy_slot_table (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // [2:0] command, [11:3] slot_index, [43:12] element_value
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [ost_pkg::InW-1:0]   s_axis_tdata,
  // [31:0] read_value, [39:32] found_index, [40] found, [42:41] status,
  // [51:43] live_count, [60:52] capacity_now
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [ost_pkg::OutW-1:0]  m_axis_tdata,
  // chunk_size write
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [ost_pkg::CntW-1:0]  cfg_data_i
);
  import ost_pkg::*;

  dp_cmd_t ctl;
  dp_sts_t sts;

  // The chunk register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  ost_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .ctl_o      (ctl),
    .sts_i      (sts)
  );

  ost_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
